@@ rtl/core/ards_pkg.sv @@
package ards_pkg;

  localparam int LEVEL_W     = 16;
  localparam int ELAPSED_W   = 16;
  localparam int TAU_W       = 16;
  localparam int FRAC_BITS   = 15;
  localparam int FULL_SCALE  = 32768;
  localparam int SNAP_LSB    = 16;
  localparam int MAX_STEP_MS = 100;

  localparam int DT_W       = $clog2(MAX_STEP_MS + 1);
  localparam int DIV_W      = TAU_W + 1;
  localparam int REM_W      = DIV_W + 1;
  localparam int CNT_W      = $clog2(FRAC_BITS + 1);
  localparam int PROD_W     = LEVEL_W + FRAC_BITS;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_MS  = 8'd0,
    REG_RELEASE_MS = 8'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [TAU_W-1:0] attack_ms;
    logic [TAU_W-1:0] release_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/ards_if.sv @@
interface ards_item_if;
  logic                           valid;
  logic                           ready;
  logic [ards_pkg::LEVEL_W-1:0]   target_level;
  logic [ards_pkg::ELAPSED_W-1:0] elapsed_ms;

  modport source(output valid, target_level, elapsed_ms, input ready);
  modport sink(input valid, target_level, elapsed_ms, output ready);
endinterface

interface ards_result_if;
  logic                         valid;
  logic                         ready;
  logic [ards_pkg::LEVEL_W-1:0] level;
  logic                         settled;

  modport source(output valid, level, settled, input ready);
  modport sink(input valid, level, settled, output ready);
endinterface

interface ards_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ards_pkg::CFG_IDX_W-1:0]  index;
  logic [ards_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/ards_cfg_regs.sv @@
module ards_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  ards_cfg_if.sink            cfg,
  output ards_pkg::cfg_regs_t regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      // Writes to unknown indexes are dropped.
      if (cfg.index == ards_pkg::REG_ATTACK_MS) begin
        regs.attack_ms <= cfg.data[ards_pkg::TAU_W-1:0];
      end else if (cfg.index == ards_pkg::REG_RELEASE_MS) begin
        regs.release_ms <= cfg.data[ards_pkg::TAU_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/ards_div.sv @@
module ards_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ards_pkg::DT_W-1:0]     dt,
  input  logic [ards_pkg::DIV_W-1:0]    divisor,
  output ards_pkg::div_stat_t           stat,
  output logic [ards_pkg::FRAC_BITS-1:0] quotient
);

  logic [ards_pkg::CNT_W-1:0]  count;
  logic [ards_pkg::REM_W-1:0]  rem;
  logic [ards_pkg::DIV_W-1:0]  div_reg;
  logic [ards_pkg::REM_W-1:0]  shifted;
  logic                        take;
  logic                        done;

  // Restoring division of (dt << FRAC_BITS) by divisor, one quotient bit per
  // cycle. The remainder starts at dt, which is always below the divisor.
  assign shifted = {rem[ards_pkg::REM_W-2:0], 1'b0};
  assign take    = (shifted >= {1'b0, div_reg});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= ards_pkg::CNT_W'(ards_pkg::FRAC_BITS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == ards_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= ards_pkg::REM_W'(dt);
      div_reg  <= divisor;
      quotient <= '0;
    end else if (count != '0) begin
      rem      <= take ? (shifted - {1'b0, div_reg}) : shifted;
      quotient <= {quotient[ards_pkg::FRAC_BITS-2:0], take};
    end
  end

  assign stat = '{busy: (count != '0), done: done};

endmodule

@@ rtl/core/attack_release_dimming_slew.sv @@
// Attack/release brightness smoother. Each request carries a target level in
// unsigned Q1.15 and the milliseconds since the previous request; the block
// moves its stored level toward the target by dt/(tau+dt), with tau taken
// from attack_ms when the target is at or above the level and release_ms
// otherwise, and returns one result per request. A request with a nonzero
// time constant passes from acceptance to the result register in order: the
// serial divider produces one bit of alpha per cycle, the sequencer sees the
// divider finish, then the multiply (ST_MUL) and the final update (ST_FIN).
// With a zero time constant the request goes straight to the final update.
// The final update waits for as long as an earlier result is still held and
// not taken. Input ready is low while a request is in work and during reset,
// and the next request can be accepted as soon as the result is latched, even
// if it has not been taken yet.
module attack_release_dimming_slew (
  input  logic       clk,
  input  logic       rst,
  ards_item_if.sink  item,
  ards_result_if.source result,
  ards_cfg_if.sink   cfg
);

  ards_pkg::state_t    state;
  ards_pkg::state_t    state_next;
  ards_pkg::cfg_regs_t regs;
  ards_pkg::div_stat_t div_stat;

  logic [ards_pkg::LEVEL_W-1:0]   current_level;
  logic [ards_pkg::LEVEL_W-1:0]   target_r;
  logic [ards_pkg::LEVEL_W-1:0]   mag_r;
  logic                           neg_r;
  logic                           zero_tau_r;
  logic [ards_pkg::PROD_W-1:0]    prod_r;
  logic [ards_pkg::FRAC_BITS-1:0] alpha;

  logic                           accept;
  logic                           div_start;
  logic                           load_out;
  logic                           out_free;
  logic                           rising;
  logic [ards_pkg::TAU_W-1:0]     tau;
  logic [ards_pkg::DT_W-1:0]      dt;
  logic [ards_pkg::DIV_W-1:0]     divisor;

  logic [ards_pkg::LEVEL_W-1:0]   move;
  logic [ards_pkg::LEVEL_W-1:0]   moved;
  logic [ards_pkg::LEVEL_W-1:0]   raw_next;
  logic [ards_pkg::LEVEL_W-1:0]   level_next;
  logic                           snap;

  ards_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ards_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dt       (dt),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (alpha)
  );

  assign accept   = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;
  assign rising   = (item.target_level >= current_level);
  assign tau      = rising ? regs.attack_ms : regs.release_ms;
  assign dt       = (item.elapsed_ms > ards_pkg::ELAPSED_W'(ards_pkg::MAX_STEP_MS)) ?
                    ards_pkg::DT_W'(ards_pkg::MAX_STEP_MS) :
                    item.elapsed_ms[ards_pkg::DT_W-1:0];
  assign divisor  = ards_pkg::DIV_W'(tau) + ards_pkg::DIV_W'(dt);

  always_comb begin
    state_next = state;
    unique case (state)
      ards_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (tau == '0) ? ards_pkg::ST_FIN : ards_pkg::ST_DIV;
        end
      end
      ards_pkg::ST_DIV: begin
        if (div_stat.done && !div_stat.busy) begin
          state_next = ards_pkg::ST_MUL;
        end
      end
      ards_pkg::ST_MUL: state_next = ards_pkg::ST_FIN;
      ards_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = ards_pkg::ST_IDLE;
        end
      end
      default: state_next = ards_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == ards_pkg::ST_IDLE) && !rst;
    div_start  = (state == ards_pkg::ST_IDLE) && accept && (tau != '0);
    load_out   = (state == ards_pkg::ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ards_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r   <= item.target_level;
      neg_r      <= !rising;
      zero_tau_r <= (tau == '0);
      mag_r      <= rising ? (item.target_level - current_level)
                           : (current_level - item.target_level);
    end
    if (state == ards_pkg::ST_MUL) begin
      prod_r <= ards_pkg::PROD_W'(mag_r) * ards_pkg::PROD_W'(alpha);
    end
  end

  // The move never exceeds the gap, so neither direction can wrap, and the
  // remaining gap is simply the magnitude minus the move.
  assign move     = prod_r[ards_pkg::PROD_W-1:ards_pkg::FRAC_BITS];
  assign moved    = neg_r ? (current_level - move) : (current_level + move);
  assign snap     = ((mag_r - move) < ards_pkg::LEVEL_W'(ards_pkg::SNAP_LSB));
  assign raw_next = (zero_tau_r || snap) ? target_r : moved;
  assign level_next = (raw_next > ards_pkg::LEVEL_W'(ards_pkg::FULL_SCALE)) ?
                      ards_pkg::LEVEL_W'(ards_pkg::FULL_SCALE) : raw_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (load_out) begin
        current_level <= level_next;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.level   <= level_next;
      result.settled <= (level_next == target_r);
    end
  end

endmodule

@@ rtl/core/ards_checker.sv @@
module ards_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [ards_pkg::LEVEL_W-1:0] result_level,
  input logic                         result_settled
);

  // A stalled result keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_level) &&
    $stable(result_settled))
    else $error("stalled result changed");

  // Levels never leave the Q1.15 range.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_level <= ards_pkg::LEVEL_W'(ards_pkg::FULL_SCALE))
    else $error("level above full scale");

  // One request at a time: the block goes busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready stayed high after accept");

  // A result never rises at once on the accept of its request.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared in the accept cycle");

endmodule

bind attack_release_dimming_slew ards_checker u_ards_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_level   (result.level),
  .result_settled (result.settled)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import ards_pkg::*;

  // Register indexes that the block must accept and ignore.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  localparam int PHASES      = 6;
  localparam int PHASE_STEPS = 255;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               settled;
  } level_result_t;

  class level_tracker;
    logic [TAU_W-1:0] attack_ms;
    logic [TAU_W-1:0] release_ms;
    int               level;
    level_result_t    expected_levels[$];
    int               failures;
    int               checked;

    function new();
      attack_ms  = '0;
      release_ms = '0;
      level      = 0;
      failures   = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ATTACK_MS) attack_ms = val;
      else if (idx == REG_RELEASE_MS) release_ms = val;
    endfunction

    // Works out the new level for one accepted request and queues it.
    function void accept_step(logic [LEVEL_W-1:0] tgt_in, logic [ELAPSED_W-1:0] dt_in);
      int unsigned     dt;
      int unsigned     tau;
      longint unsigned alpha;
      longint unsigned mag;
      longint unsigned move;
      int              tgt;
      int              diff;
      int              nxt;
      int              gap;
      level_result_t   r;
      tgt = tgt_in;
      dt  = dt_in;
      if (dt > MAX_STEP_MS) dt = MAX_STEP_MS;
      tau = (tgt >= level) ? attack_ms : release_ms;
      if (tau == 0) begin
        nxt = tgt;
      end else begin
        alpha = (longint'(dt) << FRAC_BITS) / longint'(tau + dt);
        diff  = tgt - level;
        mag   = (diff < 0) ? -diff : diff;
        move  = (mag * alpha) >> FRAC_BITS;
        nxt   = (diff < 0) ? level - int'(move) : level + int'(move);
        gap   = tgt - nxt;
        if (gap < 0) gap = -gap;
        if (gap < SNAP_LSB) nxt = tgt;
      end
      if (nxt < 0) nxt = 0;
      if (nxt > FULL_SCALE) nxt = FULL_SCALE;
      level     = nxt;
      r.level   = nxt[LEVEL_W-1:0];
      r.settled = (nxt == tgt);
      expected_levels.push_back(r);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("%t: mismatch: %s", $realtime, what);
    endfunction

    function void compare_result(logic [LEVEL_W-1:0] lvl, logic stl);
      level_result_t e;
      if (expected_levels.size() == 0) begin
        report($sformatf("result level=%0d settled=%0b with none outstanding", lvl, stl));
        return;
      end
      e = expected_levels.pop_front();
      checked++;
      if (lvl !== e.level)
        report($sformatf("level expected %0d actual %0d", e.level, lvl));
      if (stl !== e.settled)
        report($sformatf("settled expected %0b actual %0b", e.settled, stl));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;
  int   settings;
  int   steps;

  level_tracker tracker;

  ards_item_if   item_ch();
  ards_result_if res_ch();
  ards_cfg_if    cfg_ch();

  attack_release_dimming_slew i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(res_ch),
    .cfg   (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk) begin
    res_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) tracker.compare_result(res_ch.level, res_ch.settled);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_taus(input logic [TAU_W-1:0] atk, input logic [TAU_W-1:0] rel);
    write_reg(REG_ATTACK_MS, atk);
    write_reg(REG_RELEASE_MS, rel);
    settings++;
  endtask

  task automatic send_step(input logic [LEVEL_W-1:0] tgt, input logic [ELAPSED_W-1:0] dt);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.target_level <= tgt;
    item_ch.elapsed_ms   <= dt;
    do @(posedge clk); while (!item_ch.ready);
    tracker.accept_step(tgt, dt);
    steps++;
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (tracker.expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [TAU_W-1:0] pick_tau();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(2, 60));
      4:       return 16'($urandom_range(60, 3000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_target(int cur);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom_range(FULL_SCALE + 1, 65535));
    if (r < 22) begin
      t = cur + $urandom_range(0, 40) - 20;
      if (t < 0) t = 0;
      return 16'(t);
    end
    if (r < 30) return 16'(cur);
    if (r < 38) return ($urandom_range(0, 1) != 0) ? 16'(FULL_SCALE) : 16'd0;
    return 16'($urandom_range(0, FULL_SCALE));
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'($urandom_range(MAX_STEP_MS + 1, 65535));
    if (r < 12) return '0;
    if (r < 20) return 16'(MAX_STEP_MS);
    return 16'($urandom_range(1, MAX_STEP_MS - 1));
  endfunction

  initial begin
    int wait_cycles;
    tracker              = new();
    calm                 = 1'b0;
    settings             = 0;
    steps                = 0;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.target_level = '0;
    item_ch.elapsed_ms   = '0;
    res_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_ATTACK_MS;
    cfg_ch.data          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero time constants after reset: every request jumps to its target, clamped to full scale.
    send_step(16'(FULL_SCALE), 16'd5);
    send_step(16'd0, 16'd0);
    send_step(16'hFFFF, 16'd1);
    send_step(16'd0, 16'hFFFF);
    drain();

    set_taus(16'd100, 16'd1000);
    send_step(16'(FULL_SCALE), 16'(MAX_STEP_MS));
    send_step(16'(FULL_SCALE), 16'hFFFF);
    send_step(16'(FULL_SCALE), 16'd0);
    send_step(16'(tracker.level), 16'd37);
    send_step(16'(tracker.level - 10), 16'd0);
    send_step(16'd0, 16'd50);
    send_step(16'd0, 16'(MAX_STEP_MS + 1));
    send_step(16'hFFFF, 16'(MAX_STEP_MS));
    drain();

    // Ignored indexes must not disturb the time constants.
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_TOP, 16'h5A5A);
    send_step(16'd12345, 16'd20);
    drain();

    set_taus(16'hFFFF, 16'hFFFF);
    send_step(16'(FULL_SCALE), 16'd1);
    send_step(16'hFFFF, 16'(MAX_STEP_MS));
    send_step(16'd0, 16'(MAX_STEP_MS));
    drain();

    set_taus(16'd1, 16'd0);
    send_step(16'(FULL_SCALE), 16'(MAX_STEP_MS));
    send_step(16'd1000, 16'd1);
    send_step(16'd20000, 16'd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) set_taus(16'hFFFF, 16'd0);
      else set_taus(pick_tau(), pick_tau());
      calm = (p == 2);
      for (int i = 0; i < PHASE_STEPS; i++) begin
        send_step(pick_target(tracker.level), pick_elapsed());
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end
    calm = 1'b0;

    wait_cycles = 0;
    while (tracker.expected_levels.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (tracker.expected_levels.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.expected_levels.size()));

    $display("Ran %0d smoothing steps across %0d time-constant settings; %0d results compared.",
             steps, settings, tracker.checked);
    $display("%0d mismatches in total.", tracker.failures);
    if (tracker.failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
